FILE: design/tsst_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp span tracker package
// Widths, register map, and the word formats that pass between the front
// part, the middle queue, and the back part of the tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsst_pkg;

	// Field widths.
	localparam int STAMP_W = 63;
	localparam int TIME_W  = 64;
	localparam int FP_W    = 32;
	localparam int GAP_W   = 40;
	localparam int CNT_W   = 32;

	// Configuration port: 64-bit data, registers at 8-byte steps.
	localparam int CFG_DATA_W     = 64;
	localparam int REG_IDX_W      = 2;
	localparam int REG_BYTE_SHIFT = 3;
	localparam int CFG_ADDR_W     = REG_IDX_W + REG_BYTE_SHIFT;

	// Middle queue depth.
	localparam int MID_DEPTH = 4;
	localparam int MID_PTR_W = $clog2(MID_DEPTH);
	localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

	// Register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_FRAME_LEN     = 2'd0,
		REG_MAX_FWD_GAP   = 2'd1,
		REG_MAX_BACK_STEP = 2'd2
	} reg_idx_t;

	// Configuration register set.
	typedef struct packed {
		logic [FP_W-1:0]  frame_len;
		logic [GAP_W-1:0] max_fwd_gap;
		logic [GAP_W-1:0] max_back_step;
	} cfg_t;

	// Classified word handed from the front part to the back part.
	// Times are biased by 2^62 so that all compares are unsigned.
	typedef struct packed {
		logic               stamp_valid;
		logic [STAMP_W-1:0] pkt_start;   // biased stamp
		logic [TIME_W-1:0]  pkt_end;     // biased stamp plus duration
		logic [TIME_W-1:0]  start_back;  // biased stamp plus backward limit
		logic [TIME_W-1:0]  prod;        // untimed run times frame period
		logic [TIME_W:0]    slack;       // prod plus forward limit
	} mid_t;

	// Result word.
	typedef struct packed {
		logic               break_seen;
		logic [CNT_W-1:0]   break_count;
		logic [STAMP_W-1:0] covered_time;
	} res_t;

	// Queue status.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

FILE: design/tsst_front.sv
// ----------------------------------------------------------------------------
// Tracker front part
// Accepts words, keeps the untimed packet run, and prepares each word for
// the segment update: biased times, effective duration and run product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsst_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsst_pkg::cfg_t               cfg,
	input  logic                         push,
	output logic                         full,
	input  logic                         stamp_valid,
	input  logic signed [tsst_pkg::STAMP_W-1:0] stamp,
	input  logic [tsst_pkg::FP_W-1:0]    span,
	output logic                         q_push,
	output tsst_pkg::mid_t               q_data,
	input  tsst_pkg::qstat_t             q_stat
);
	import tsst_pkg::*;

	logic              accept;
	logic              s1_ready;
	logic              s2_ready;
	logic              s1_move;
	logic [FP_W-1:0]   run_q;
	logic [FP_W-1:0]   run_inc;

	logic              valid_s1;
	logic              stamp_valid_s1;
	logic [STAMP_W-1:0] stamp_s1;
	logic [FP_W-1:0]   span_s1;
	logic [FP_W-1:0]   run_s1;

	logic              valid_s2;
	logic              stamp_valid_s2;
	logic [STAMP_W-1:0] pkt_start_s2;
	logic [TIME_W-1:0] pkt_end_s2;
	logic [TIME_W-1:0] start_back_s2;
	logic [TIME_W-1:0] prod_s2;

	logic [STAMP_W-1:0] biased;
	logic [FP_W-1:0]   dur;
	logic [TIME_W-1:0] prod;

	// Stage handshake: a stage takes a word when it is empty or drains.
	assign s2_ready = !valid_s2 || !q_stat.full;
	assign s1_ready = !valid_s1 || s2_ready;
	assign full     = !s1_ready;
	assign accept   = push && s1_ready;
	assign s1_move  = valid_s1 && s2_ready;

	// Untimed run, saturating.
	assign run_inc = (run_q == '1) ? run_q : run_q + FP_W'(1);

	// Bias the stamp by 2^62, substitute the frame period for a zero span.
	assign biased = {~stamp_s1[STAMP_W-1], stamp_s1[STAMP_W-2:0]};
	assign dur    = (span_s1 == '0) ? cfg.frame_len : span_s1;
	assign prod   = TIME_W'(run_s1) * TIME_W'(cfg.frame_len);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				run_q <= stamp_valid ? '0 : run_inc;
			end
			valid_s1 <= accept || (valid_s1 && !s2_ready);
			valid_s2 <= s1_move || (valid_s2 && q_stat.full);
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (accept) begin
			stamp_valid_s1 <= stamp_valid;
			stamp_s1       <= stamp;
			span_s1        <= span;
			run_s1         <= stamp_valid ? run_q : run_inc;
		end
		if (s1_move) begin
			stamp_valid_s2 <= stamp_valid_s1;
			pkt_start_s2   <= biased;
			pkt_end_s2     <= TIME_W'(biased) + TIME_W'(dur);
			start_back_s2  <= TIME_W'(biased) + TIME_W'(cfg.max_back_step);
			prod_s2        <= prod;
		end
	end

	// Word into the middle queue.
	assign q_push            = valid_s2 && !q_stat.full;
	assign q_data.stamp_valid = stamp_valid_s2;
	assign q_data.pkt_start  = pkt_start_s2;
	assign q_data.pkt_end    = pkt_end_s2;
	assign q_data.start_back = start_back_s2;
	assign q_data.prod       = prod_s2;
	assign q_data.slack      = (TIME_W+1)'(prod_s2) + (TIME_W+1)'(cfg.max_fwd_gap);

endmodule

`default_nettype wire

FILE: design/tsst_queue.sv
// ----------------------------------------------------------------------------
// Tracker middle queue
// A short first-in first-out store that decouples the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsst_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tsst_pkg::mid_t   wr_data,
	input  logic             pop,
	output tsst_pkg::mid_t   rd_data,
	output tsst_pkg::qstat_t stat
);
	import tsst_pkg::*;

	mid_t                 entries_q [MID_DEPTH];
	logic [MID_PTR_W-1:0] wr_ptr_q;
	logic [MID_PTR_W-1:0] rd_ptr_q;
	logic [MID_CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == MID_CNT_W'(MID_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_data    = entries_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + MID_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + MID_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + MID_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - MID_CNT_W'(1);
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: design/tsst_back.sv
// ----------------------------------------------------------------------------
// Tracker back part
// Runs the segment update, one word a cycle while the output queue has room;
// then forms the covered time and puts the result in a two-entry output queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsst_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tsst_pkg::qstat_t q_stat,
	input  tsst_pkg::mid_t   q_data,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output tsst_pkg::res_t   res
);
	import tsst_pkg::*;

	// Segment state.
	logic [TIME_W-1:0]  next_exp_q;
	logic               next_known_q;
	logic               seg_known_q;
	logic [STAMP_W-1:0] seg_start_q;
	logic [TIME_W-1:0]  seg_end_q;
	logic [TIME_W-1:0]  seg_len_q;
	logic               seg_pos_q;
	logic [STAMP_W-1:0] closed_q;
	logic [CNT_W-1:0]   breaks_q;

	// Update stage.
	logic               valid_s1;
	logic               brk_s1;
	logic [CNT_W-1:0]   count_s1;
	logic [STAMP_W-1:0] closed_s1;
	logic [TIME_W-1:0]  len_s1;
	logic               pos_s1;
	logic [TIME_W-1:0]  prod_s1;

	// Output queue.
	res_t               oq_q [2];
	logic               oq_wr_q;
	logic               oq_rd_q;
	logic [1:0]         oq_cnt_q;

	logic               out_pop;
	logic               oq_room;
	logic               oq_push;
	logic               s1_ready;
	logic               timed;

	logic [TIME_W:0]    exp_sum;
	logic [TIME_W+1:0]  fwd_sum;
	logic               fwd;
	logic               bck;
	logic               brk;
	logic [TIME_W:0]    len_old;
	logic [TIME_W+1:0]  closed_sum;
	logic [STAMP_W-1:0] closed_brk;
	logic               known_eff;
	logic [STAMP_W-1:0] start_nx;
	logic [TIME_W-1:0]  end_nx;
	logic [TIME_W:0]    diff;
	logic [STAMP_W-1:0] closed_nx;
	logic [TIME_W-1:0]  len_nx;
	logic               pos_nx;
	logic [CNT_W-1:0]   breaks_nx;

	logic [TIME_W+1:0]  total;
	res_t               res_nx;

	// Handshake: the output queue frees a slot in the cycle it is popped.
	assign out_pop  = pop && (oq_cnt_q != 2'd0);
	assign oq_room  = (oq_cnt_q != 2'd2) || out_pop;
	assign oq_push  = valid_s1 && oq_room;
	assign s1_ready = !valid_s1 || oq_room;
	assign q_pop    = !q_stat.empty && s1_ready;
	assign timed    = q_pop && q_data.stamp_valid;

	// Break test against the expected time, with exact wide sums.
	always_comb begin
		exp_sum = (TIME_W+1)'(next_exp_q) + (TIME_W+1)'(q_data.prod);
		fwd_sum = (TIME_W+2)'(next_exp_q) + (TIME_W+2)'(q_data.slack);
		fwd     = (TIME_W+2)'(q_data.pkt_start) > fwd_sum;
		bck     = (TIME_W+1)'(q_data.start_back) < exp_sum;
		brk     = timed && next_known_q && (fwd || bck);
	end

	// Closing the open segment and growing the new one.
	always_comb begin
		len_old    = seg_pos_q ? (TIME_W+1)'(seg_len_q) + (TIME_W+1)'(q_data.prod) : '0;
		closed_sum = (TIME_W+2)'(closed_q) + (TIME_W+2)'(len_old);
		closed_brk = (closed_sum[TIME_W+1:STAMP_W] != '0) ? '1 : closed_sum[STAMP_W-1:0];
		known_eff  = seg_known_q && !brk;
		start_nx   = (!known_eff || (q_data.pkt_start < seg_start_q)) ?
			q_data.pkt_start : seg_start_q;
		end_nx     = (!known_eff || (q_data.pkt_end > seg_end_q)) ?
			q_data.pkt_end : seg_end_q;
		diff       = (TIME_W+1)'(end_nx) - (TIME_W+1)'(start_nx);
		closed_nx  = brk ? closed_brk : closed_q;
		len_nx     = timed ? diff[TIME_W-1:0] : seg_len_q;
		pos_nx     = timed ? (!diff[TIME_W] && (diff != '0)) : seg_pos_q;
		breaks_nx  = (brk && (breaks_q != '1)) ? breaks_q + CNT_W'(1) : breaks_q;
	end

	// Segment state and update-stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_exp_q   <= '0;
			next_known_q <= 1'b0;
			seg_known_q  <= 1'b0;
			seg_start_q  <= '0;
			seg_end_q    <= '0;
			seg_len_q    <= '0;
			seg_pos_q    <= 1'b0;
			closed_q     <= '0;
			breaks_q     <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (timed) begin
				next_exp_q   <= q_data.pkt_end;
				next_known_q <= 1'b1;
				seg_known_q  <= 1'b1;
				seg_start_q  <= start_nx;
				seg_end_q    <= end_nx;
				seg_len_q    <= len_nx;
				seg_pos_q    <= pos_nx;
				closed_q     <= closed_nx;
				breaks_q     <= breaks_nx;
			end
			valid_s1 <= q_pop || (valid_s1 && !oq_room);
		end
	end

	// Snapshot of the state that the result is formed from.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			brk_s1    <= brk;
			count_s1  <= breaks_nx;
			closed_s1 <= closed_nx;
			len_s1    <= len_nx;
			pos_s1    <= pos_nx;
			prod_s1   <= q_data.stamp_valid ? '0 : q_data.prod;
		end
	end

	// Covered time: closed total plus open length, saturating.
	always_comb begin
		total = (TIME_W+2)'(closed_s1);
		if (pos_s1) begin
			total = total + (TIME_W+2)'(len_s1) + (TIME_W+2)'(prod_s1);
		end
		res_nx.break_seen   = brk_s1;
		res_nx.break_count  = count_s1;
		res_nx.covered_time = (total[TIME_W+1:STAMP_W] != '0) ? '1 : total[STAMP_W-1:0];
	end

	// Output queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= !oq_wr_q;
			end
			if (out_pop) begin
				oq_rd_q <= !oq_rd_q;
			end
			if (oq_push && !out_pop) begin
				oq_cnt_q <= oq_cnt_q + 2'd1;
			end else if (out_pop && !oq_push) begin
				oq_cnt_q <= oq_cnt_q - 2'd1;
			end
		end
	end

	// Output queue storage.
	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q] <= res_nx;
		end
	end

	assign empty = (oq_cnt_q == 2'd0);
	assign res   = oq_q[oq_rd_q];

endmodule

`default_nettype wire

FILE: design/timestamp_span_tracker_unit.sv
// ----------------------------------------------------------------------------
// Timestamp span tracker
// Measures the stream time covered by packet timestamps and counts the
// discontinuities between segments.
// ----------------------------------------------------------------------------
// The unit takes one word per clock while full is low and gives one result
// word for each, in order. A result reaches the result ports through five
// register stages (two front stages, the middle queue, the update stage and
// the output queue), and one word a cycle is sustained while results are
// popped, set by the segment update in the back part; the 32 by 32 run
// product is formed in the front part ahead of it.
// Configuration registers sit at byte addresses 0, 8 and 16 and are to be
// written only while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_span_tracker_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input queue side
	input  logic                                push,
	output logic                                full,
	input  logic                                stamp_valid,
	input  logic signed [tsst_pkg::STAMP_W-1:0] stamp,
	input  logic [tsst_pkg::FP_W-1:0]           span,
	// Result queue side
	output logic                                empty,
	input  logic                                pop,
	output logic                                break_seen,
	output logic [tsst_pkg::CNT_W-1:0]          break_count,
	output logic [tsst_pkg::STAMP_W-1:0]        covered_time,
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tsst_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [tsst_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [tsst_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import tsst_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	logic     q_push;
	logic     q_pop;
	mid_t     q_wr_data;
	mid_t     q_rd_data;
	qstat_t   q_stat;
	res_t     res;

	// Register access.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:REG_BYTE_SHIFT]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FRAME_LEN:     cfg_q.frame_len     <= pwdata[FP_W-1:0];
				REG_MAX_FWD_GAP:   cfg_q.max_fwd_gap   <= pwdata[GAP_W-1:0];
				REG_MAX_BACK_STEP: cfg_q.max_back_step <= pwdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRAME_LEN:     prdata = CFG_DATA_W'(cfg_q.frame_len);
			REG_MAX_FWD_GAP:   prdata = CFG_DATA_W'(cfg_q.max_fwd_gap);
			REG_MAX_BACK_STEP: prdata = CFG_DATA_W'(cfg_q.max_back_step);
			default:           prdata = '0;
		endcase
	end

	// Front part: accept and classify.
	tsst_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.stamp_valid (stamp_valid),
		.stamp       (stamp),
		.span        (span),
		.q_push      (q_push),
		.q_data      (q_wr_data),
		.q_stat      (q_stat)
	);

	// Queue between the two parts.
	tsst_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr_data),
		.pop     (q_pop),
		.rd_data (q_rd_data),
		.stat    (q_stat)
	);

	// Back part: segment update and results.
	tsst_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_data (q_rd_data),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.res    (res)
	);

	assign break_seen   = res.break_seen;
	assign break_count  = res.break_count;
	assign covered_time = res.covered_time;

`ifndef SYNTHESIS
	// The back part never takes a word from an empty middle queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("middle queue popped while empty");

	// A result that reports a break carries a non-zero break count.
	a_break_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && break_seen) |-> (break_count != '0))
		else $error("break reported with zero count");

	// The break count never falls from one result word to the next.
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) |=> (empty || (break_count >= $past(break_count))))
		else $error("break count fell between results");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/timestamp_span_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// Timestamp span tracker testbench
// Drives packet words into the tracker through its push/full side and pops
// results at a varying pace. A scoreboard keeps its own copy of the segment
// state, predicts the break flag, break count and covered time of every
// word, and compares each popped result with the oldest prediction. The
// registers are set between phases and read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timestamp_span_tracker_unit_tb;
	import tsst_pkg::*;

	localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] BIAS  = 64'h4000_0000_0000_0000;
	localparam logic signed [STAMP_W-1:0] STAMP_LO = {1'b1, {(STAMP_W-1){1'b0}}};
	localparam logic signed [STAMP_W-1:0] STAMP_HI = {1'b0, {(STAMP_W-1){1'b1}}};
	localparam int RANDOM_WORDS = 1400;
	localparam int RANDOM_PHASES = 6;

	// Scoreboard: segment tracking predictor and the queue of due results.
	class span_scoreboard;
		logic [FP_W-1:0]   frame_len;
		logic [GAP_W-1:0]  fwd_limit;
		logic [GAP_W-1:0]  back_limit;
		logic [TIME_W-1:0] seg_lo, seg_hi, resume_at, closed_len;
		bit                lo_known, hi_known, resume_known;
		logic [31:0]       untimed_cnt;
		logic [CNT_W-1:0]  gaps_seen;
		res_t              results_due[$];
		int                mismatches, timed_words, untimed_words;
		int                results_checked, breaks_checked;

		function new();
			frame_len = '0; fwd_limit = '0; back_limit = '0;
			seg_lo = '0; seg_hi = '0; resume_at = '0; closed_len = '0;
			lo_known = 0; hi_known = 0; resume_known = 0;
			untimed_cnt = '0; gaps_seen = '0;
			mismatches = 0; timed_words = 0; untimed_words = 0;
			results_checked = 0; breaks_checked = 0;
		endfunction

		function void fail(string what, logic [63:0] want, logic [63:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t",
					what, want, got, $time);
		endfunction

		function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
			logic [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[64] ? '1 : s[63:0];
		endfunction

		function logic [63:0] run_product();
			return 64'(untimed_cnt) * 64'(frame_len);
		endfunction

		// Length of the open segment, extended by the untimed run.
		function logic [63:0] open_length();
			if (!lo_known || !hi_known || seg_hi <= seg_lo)
				return '0;
			return sat_sum(seg_hi - seg_lo, run_product());
		endfunction

		function void set_reg(reg_idx_t idx, logic [63:0] value);
			case (idx)
				REG_FRAME_LEN:     frame_len = value[FP_W-1:0];
				REG_MAX_FWD_GAP:   fwd_limit = value[GAP_W-1:0];
				REG_MAX_BACK_STEP: back_limit = value[GAP_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] reg_value(reg_idx_t idx);
			case (idx)
				REG_FRAME_LEN:     return 64'(frame_len);
				REG_MAX_FWD_GAP:   return 64'(fwd_limit);
				REG_MAX_BACK_STEP: return 64'(back_limit);
				default:           return '0;
			endcase
		endfunction

		// Accepted word: update the segment state and queue its result.
		function void note_packet(bit timed, logic [STAMP_W-1:0] stamp, logic [FP_W-1:0] span);
			bit          brk;
			logic [63:0] u, dur, pkt_end, due, total;
			res_t        r;
			brk = 0;
			if (!timed) begin
				untimed_words++;
				if (untimed_cnt != '1)
					untimed_cnt++;
			end else begin
				timed_words++;
				u = {1'b0, stamp} ^ BIAS;
				dur = (span == '0) ? 64'(frame_len) : 64'(span);
				pkt_end = u + dur;
				if (resume_known) begin
					due = sat_sum(resume_at, run_product());
					if (u > sat_sum(due, 64'(fwd_limit)) || (u + 64'(back_limit)) < due) begin
						closed_len = sat_sum(closed_len, open_length());
						if (closed_len > MAX63)
							closed_len = MAX63;
						lo_known = 0;
						hi_known = 0;
						if (gaps_seen != '1)
							gaps_seen++;
						brk = 1;
					end
				end
				untimed_cnt = '0;
				if (!lo_known || u < seg_lo) begin
					seg_lo = u;
					lo_known = 1;
				end
				if (!hi_known || pkt_end > seg_hi) begin
					seg_hi = pkt_end;
					hi_known = 1;
				end
				resume_at = pkt_end;
				resume_known = 1;
			end
			total = sat_sum(closed_len, open_length());
			if (total > MAX63)
				total = MAX63;
			r.break_seen = brk;
			r.break_count = gaps_seen;
			r.covered_time = total[STAMP_W-1:0];
			results_due.push_back(r);
		endfunction

		// Popped result: compare with the oldest prediction.
		function void check_result(res_t got);
			res_t want;
			if (results_due.size() == 0) begin
				fail("result word with nothing due", '0, 64'(got));
				return;
			end
			want = results_due.pop_front();
			results_checked++;
			if (got.break_seen)
				breaks_checked++;
			if (got.break_seen !== want.break_seen)
				fail("break_seen", 64'(want.break_seen), 64'(got.break_seen));
			if (got.break_count !== want.break_count)
				fail("break_count", 64'(want.break_count), 64'(got.break_count));
			if (got.covered_time !== want.covered_time)
				fail("covered_time", 64'(want.covered_time), 64'(got.covered_time));
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         push = 1'b0;
	logic                         full;
	logic                         stamp_valid = 1'b0;
	logic signed [STAMP_W-1:0]    stamp = '0;
	logic [FP_W-1:0]              span = '0;
	logic                         empty;
	logic                         pop = 1'b0;
	logic                         break_seen;
	logic [CNT_W-1:0]             break_count;
	logic [STAMP_W-1:0]           covered_time;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0]        paddr = '0;
	logic [CFG_DATA_W-1:0]        pwdata = '0;
	logic [CFG_DATA_W-1:0]        prdata;
	logic                         pready;

	span_scoreboard               sb = new();
	int unsigned                  hold_cycles = 0;
	int                           settings_used = 0;
	logic signed [STAMP_W-1:0]    flow_pos = '0;

	timestamp_span_tracker_unit uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.stamp_valid(stamp_valid), .stamp(stamp), .span(span),
		.empty(empty), .pop(pop),
		.break_seen(break_seen), .break_count(break_count), .covered_time(covered_time),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Both handshakes are observed at the rising edge.
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (push && !full)
				sb.note_packet(stamp_valid, stamp, span);
			if (pop && !empty) begin
				got.break_seen = break_seen;
				got.break_count = break_count;
				got.covered_time = covered_time;
				sb.check_result(got);
			end
		end
	end

	// Receiver: a stall pattern that is redrawn after a random run, plus
	// long hold-offs on request.
	initial begin : receiver
		int unsigned mode_left;
		int unsigned mode;
		mode_left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				pop <= 1'b0;
				hold_cycles--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(3);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(1));
					2: pop <= ($urandom_range(3) == 0);
					default: pop <= (mode_left % 3 == 0);
				endcase
			end
		end
	end

	// Offer one word and hold it until it is taken; returns at a falling edge.
	task send_packet(input bit timed, input logic signed [STAMP_W-1:0] s,
			input logic [FP_W-1:0] d);
		push <= 1'b1;
		stamp_valid <= timed;
		stamp <= s;
		span <= d;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task sender_gap(input int unsigned cycles);
		push <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Wait until every due result has been popped, then let the pipe drain.
	task settle();
		push <= 1'b0;
		while (sb.results_due.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Register write followed by a read back of the same register.
	task program_reg(input reg_idx_t idx, input logic [63:0] value);
		logic [63:0] readback;
		paddr <= CFG_ADDR_W'(idx) << REG_BYTE_SHIFT;
		pwdata <= value;
		pwrite <= 1'b1;
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, value);
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		if (readback !== sb.reg_value(idx))
			sb.fail("register read back", sb.reg_value(idx), readback);
	endtask

	task program_all(input logic [63:0] fp, input logic [63:0] fg, input logic [63:0] bs);
		program_reg(REG_FRAME_LEN, fp);
		program_reg(REG_MAX_FWD_GAP, fg);
		program_reg(REG_MAX_BACK_STEP, bs);
		settings_used++;
	endtask

	// Register settings for each random phase, the extremes among them.
	task pick_settings(input int ph);
		case (ph)
			0: program_all($urandom_range(1, 3000), $urandom_range(0, 2000),
				$urandom_range(0, 2000));
			1: program_all('0, '0, '0);
			2: program_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
			3: program_all('1, '1, '1);
			default: program_all($urandom_range(1, 50000), $urandom_range(0, 100000),
				$urandom_range(0, 100000));
		endcase
	endtask

	function automatic logic [FP_W-1:0] draw_span();
		case ($urandom_range(3))
			0: return '0;
			1: return (sb.frame_len == '0) ? FP_W'($urandom_range(1, 2000)) : sb.frame_len;
			default: return FP_W'($urandom_range(1, 5000));
		endcase
	endfunction

	// Offset from the expected time: mostly within limits, some exactly on
	// a limit, some just past one.
	function automatic logic signed [63:0] draw_offset();
		logic signed [63:0] lim_f, lim_b;
		int unsigned        pick;
		lim_f = (sb.fwd_limit > 40'h10_0000) ? 64'sh10_0000 : 64'(sb.fwd_limit);
		lim_b = (sb.back_limit > 40'h10_0000) ? 64'sh10_0000 : 64'(sb.back_limit);
		pick = $urandom_range(99);
		if (pick < 38)
			return 64'($urandom_range(0, 32'(lim_f)));
		else if (pick < 72)
			return -64'($urandom_range(0, 32'(lim_b)));
		else if (pick < 77)
			return 64'(sb.fwd_limit);
		else if (pick < 82)
			return -64'(sb.back_limit);
		else if (pick < 91)
			return 64'(sb.fwd_limit) + 1 + 64'($urandom_range(0, 5000));
		else
			return -(64'(sb.back_limit) + 1 + 64'($urandom_range(0, 5000)));
	endfunction

	// One random word: mostly a well-formed stream around the expected time,
	// with untimed packets and some pure noise.
	task send_random_packet();
		int unsigned               pick;
		logic signed [STAMP_W-1:0] s;
		logic [FP_W-1:0]           d;
		pick = $urandom_range(99);
		if (pick < 8) begin
			s = STAMP_W'({$urandom, $urandom});
			d = $urandom;
			if (pick < 4) begin
				flow_pos = s + STAMP_W'((d == '0) ? sb.frame_len : d);
				send_packet(1'b1, s, d);
			end else begin
				flow_pos = flow_pos + STAMP_W'(sb.frame_len);
				send_packet(1'b0, s, d);
			end
		end else if (pick < 22) begin
			flow_pos = flow_pos + STAMP_W'(sb.frame_len);
			send_packet(1'b0, STAMP_W'({$urandom, $urandom}), $urandom);
		end else begin
			d = draw_span();
			s = flow_pos + STAMP_W'(draw_offset());
			flow_pos = s + STAMP_W'((d == '0) ? sb.frame_len : d);
			send_packet(1'b1, s, d);
		end
	endtask

	// Run limit.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Main sequence.
	initial begin
		int unsigned burst_left;
		int          per_phase;
		int          failures;
		burst_left = 0;
		per_phase = RANDOM_WORDS / RANDOM_PHASES;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Registers at reset values: zero span, zero limits, exact hits.
		send_packet(1'b0, STAMP_HI, '1);
		send_packet(1'b1, STAMP_LO, '0);
		send_packet(1'b1, STAMP_LO, 32'd5);
		send_packet(1'b1, STAMP_LO + 5, 32'd1);
		send_packet(1'b1, STAMP_LO + 7, 32'd1);
		send_packet(1'b1, STAMP_LO + 7, 32'd1);
		settle();

		// Extremes: largest period and limits, stamps at both ends.
		program_all('1, '1, '1);
		send_packet(1'b0, '0, '0);
		send_packet(1'b0, '1, '1);
		send_packet(1'b1, STAMP_HI, '1);
		send_packet(1'b1, STAMP_LO, '0);
		send_packet(1'b1, '1, '0);
		send_packet(1'b1, '0, '1);
		settle();

		// Moderate limits: on and just past each limit, untimed extrapolation.
		program_all(64'd1000, 64'd500, 64'd250);
		send_packet(1'b1, 63'sd1_000_000, 32'd100);
		send_packet(1'b1, 63'sd1_000_600, 32'd100);
		send_packet(1'b1, 63'sd1_001_201, 32'd100);
		send_packet(1'b1, 63'sd1_001_051, '0);
		send_packet(1'b1, 63'sd1_001_800, 32'd50);
		send_packet(1'b0, '0, '0);
		send_packet(1'b0, '0, '0);
		send_packet(1'b1, 63'sd1_003_850, 32'd1);
		send_packet(1'b1, 63'sd1_003_851, '1);
		flow_pos = 63'sd1_003_851 + 63'sd4294967295;
		settle();

		// Random phases; state carries over while the registers change.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			pick_settings(ph);
			if (ph == 4 || ph == 1)
				hold_cycles = 300;
			for (int n = 0; n < per_phase; n++) begin
				if (burst_left == 0) begin
					sender_gap($urandom_range(1, 6));
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				send_random_packet();
			end
			settle();
		end

		failures = sb.mismatches + sb.results_due.size();
		$display("Covered %0d timed and %0d untimed words over %0d register settings;",
			sb.timed_words, sb.untimed_words, settings_used);
		$display("%0d results checked, %0d of them with a break, %0d mismatches.",
			sb.results_checked, sb.breaks_checked, sb.mismatches);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
design/tsst_pkg.sv
design/tsst_front.sv
design/tsst_queue.sv
design/tsst_back.sv
design/timestamp_span_tracker_unit.sv
tb/sv/timestamp_span_tracker_unit_tb.sv
